// ===== src/cll_pkg.sv =====
// cll_pkg: shared types and codes for the cursor linked list engine
// item structs, request and status codes, controller to datapath command and status
// no dependencies
package cll_pkg;

    localparam int SLOT_W = 6;
    localparam int KEY_W  = 16;
    localparam int POS_W  = 8;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [SLOT_W-1:0]       NULL_SLOT = 6'h3f;
    localparam logic signed [POS_W-1:0] POS_END   = -8'sd1;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;
    localparam logic [REQ_W-1:0] REQ_WALK   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

    // read address select
    localparam logic [1:0] RD_CUR  = 2'd0;
    localparam logic [1:0] RD_LINK = 2'd1;
    localparam logic [1:0] RD_FREE = 2'd2;

    // link write address select
    localparam logic [1:0] WA_NEW  = 2'd0;
    localparam logic [1:0] WA_CUR  = 2'd1;
    localparam logic [1:0] WA_PREV = 2'd2;

    // link write data select
    localparam logic [1:0] WD_HEAD = 2'd0;
    localparam logic [1:0] WD_LINK = 2'd1;
    localparam logic [1:0] WD_NEW  = 2'd2;
    localparam logic [1:0] WD_FREE = 2'd3;

    // list head update
    localparam logic [1:0] HD_KEEP = 2'd0;
    localparam logic [1:0] HD_NEW  = 2'd1;
    localparam logic [1:0] HD_LINK = 2'd2;

    // free head update
    localparam logic [1:0] FR_KEEP = 2'd0;
    localparam logic [1:0] FR_LINK = 2'd1;
    localparam logic [1:0] FR_CUR  = 2'd2;

    // result register load
    localparam logic [2:0] RES_FULL      = 3'd0;
    localparam logic [2:0] RES_NOT_FOUND = 3'd1;
    localparam logic [2:0] RES_EMPTY     = 3'd2;
    localparam logic [2:0] RES_INS_OK    = 3'd3;
    localparam logic [2:0] RES_CUR_OK    = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]       req_type;
        logic [KEY_W-1:0]       key;
        logic signed [POS_W-1:0] position;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  found_key;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic       accept;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       key_wr;
        logic       new_ld;
        logic       lnk_wr;
        logic [1:0] lnk_wa;
        logic [1:0] lnk_wd;
        logic [1:0] head_sel;
        logic [1:0] free_sel;
        logic       step;
        logic       res_ld;
        logic [2:0] res_sel;
        logic       out_ld;
        logic       out_walk;
    } t_cmd;

    typedef struct packed {
        logic free_null;
        logic head_null;
        logic cur_null;
        logic prev_null;
        logic link_null;
        logic hit;
        logic cnt_full;
        logic cnt_last;
        logic pos_front;
        logic pos_go;
        logic is_delete;
        logic out_free;
    } t_stat;

endpackage

// ===== src/cll_dpath.sv =====
// cll_dpath: link and key stores, cursor registers, free and list heads, output register
// driven by command beats from cll_ctrl; uses cll_pkg
module cll_dpath #(
    parameter int SLOTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cll_pkg::t_in_item  i_in_data,
    input  logic               i_out_stall,
    input  cll_pkg::t_cmd      i_cmd,
    output cll_pkg::t_stat     o_stat,
    output logic               o_out_valid,
    output cll_pkg::t_out_item o_out_data
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = cll_pkg::SLOT_W;
    localparam logic [SW-1:0] SLOTS_S  = SW'(SLOTS);
    localparam logic [SW:0]   SLOTS_S1 = (SW + 1)'(SLOTS);
    localparam logic [CW-1:0] CNT_FULL = CW'(SLOTS);
    localparam logic [CW-1:0] CNT_LAST = CW'(SLOTS - 1);

    logic [SW-1:0]                 link_mem [SLOTS];
    logic [cll_pkg::KEY_W-1:0]     key_mem  [SLOTS];
    logic [SLOTS-1:0]              r_lv;

    logic [cll_pkg::REQ_W-1:0]        r_type;
    logic [cll_pkg::KEY_W-1:0]        r_key;
    logic signed [cll_pkg::POS_W-1:0] r_pos;
    logic [SW-1:0]                    r_cur;
    logic [SW-1:0]                    r_prev;
    logic [CW-1:0]                    r_cnt;
    logic [SW-1:0]                    r_new;
    logic [SW-1:0]                    r_head;
    logic [SW-1:0]                    r_free;

    logic [SW-1:0]             r_lq;
    logic                      r_lvq;
    logic [SW-1:0]             r_ldq;
    logic [cll_pkg::KEY_W-1:0] r_kq;

    logic [cll_pkg::STAT_W-1:0] r_res_status;
    logic [SW-1:0]              r_res_slot;
    logic [cll_pkg::KEY_W-1:0]  r_res_key;
    logic                       r_ovalid;
    cll_pkg::t_out_item         r_out;

    logic [SW-1:0] link_rd;
    logic [SW-1:0] rd_addr;
    logic [SW:0]   rd_inc;
    logic [SW-1:0] rd_dflt;
    logic [SW-1:0] wr_addr;
    logic [SW-1:0] wr_data;
    logic [SW-1:0] head_n;
    logic [SW-1:0] free_n;
    logic [SW-1:0] link_n;
    logic signed [cll_pkg::POS_W:0] pos9;
    logic signed [cll_pkg::POS_W:0] cnt9;
    logic          out_free;

    assign link_rd = r_lvq ? r_lq : r_ldq;
    assign head_n  = (r_head < SLOTS_S) ? r_head : cll_pkg::NULL_SLOT;
    assign free_n  = (r_free < SLOTS_S) ? r_free : cll_pkg::NULL_SLOT;
    assign link_n  = (link_rd < SLOTS_S) ? link_rd : cll_pkg::NULL_SLOT;

    always_comb begin
        case (i_cmd.rd_sel)
            cll_pkg::RD_LINK: rd_addr = link_rd;
            cll_pkg::RD_FREE: rd_addr = r_free;
            default:          rd_addr = r_cur;
        endcase
    end

    assign rd_inc  = {1'b0, rd_addr} + (SW + 1)'(1);
    assign rd_dflt = (rd_inc < SLOTS_S1) ? rd_inc[SW-1:0] : cll_pkg::NULL_SLOT;

    always_comb begin
        case (i_cmd.lnk_wa)
            cll_pkg::WA_CUR:  wr_addr = r_cur;
            cll_pkg::WA_PREV: wr_addr = r_prev;
            default:          wr_addr = r_new;
        endcase
    end

    always_comb begin
        case (i_cmd.lnk_wd)
            cll_pkg::WD_LINK: wr_data = link_n;
            cll_pkg::WD_NEW:  wr_data = r_new;
            cll_pkg::WD_FREE: wr_data = free_n;
            default:          wr_data = head_n;
        endcase
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.lnk_wr) begin
            link_mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (i_cmd.key_wr) begin
            key_mem[r_free[AW-1:0]] <= r_key;
        end
        if (i_cmd.rd_en) begin
            r_lq  <= link_mem[rd_addr[AW-1:0]];
            r_kq  <= key_mem[rd_addr[AW-1:0]];
            r_lvq <= r_lv[rd_addr[AW-1:0]];
            r_ldq <= rd_dflt;
        end
    end

    // cursor and item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_type <= i_in_data.req_type;
            r_key  <= i_in_data.key;
            r_pos  <= i_in_data.position;
            r_cur  <= r_head;
            r_prev <= cll_pkg::NULL_SLOT;
            r_cnt  <= '0;
        end else if (i_cmd.step) begin
            r_prev <= r_cur;
            r_cur  <= link_rd;
            r_cnt  <= r_cnt + CW'(1);
        end
        if (i_cmd.new_ld) begin
            r_new <= r_free;
        end
        if (i_cmd.res_ld) begin
            case (i_cmd.res_sel)
                cll_pkg::RES_FULL: begin
                    r_res_status <= cll_pkg::ST_FULL;
                    r_res_slot   <= '0;
                    r_res_key    <= '0;
                end
                cll_pkg::RES_EMPTY: begin
                    r_res_status <= cll_pkg::ST_EMPTY;
                    r_res_slot   <= '0;
                    r_res_key    <= '0;
                end
                cll_pkg::RES_INS_OK: begin
                    r_res_status <= cll_pkg::ST_OK;
                    r_res_slot   <= r_new;
                    r_res_key    <= r_key;
                end
                cll_pkg::RES_CUR_OK: begin
                    r_res_status <= cll_pkg::ST_OK;
                    r_res_slot   <= r_cur;
                    r_res_key    <= r_key;
                end
                default: begin
                    r_res_status <= cll_pkg::ST_NOT_FOUND;
                    r_res_slot   <= '0;
                    r_res_key    <= '0;
                end
            endcase
        end
        if (i_cmd.out_ld) begin
            if (i_cmd.out_walk) begin
                r_out.status    <= cll_pkg::ST_OK;
                r_out.slot      <= r_cur;
                r_out.found_key <= r_kq;
                r_out.last      <= o_stat.link_null || o_stat.cnt_last;
            end else begin
                r_out.status    <= r_res_status;
                r_out.slot      <= r_res_slot;
                r_out.found_key <= r_res_key;
                r_out.last      <= 1'b1;
            end
        end
    end

    // heads, link valid bits, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= cll_pkg::NULL_SLOT;
            r_free   <= '0;
            r_lv     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            case (i_cmd.head_sel)
                cll_pkg::HD_NEW:  r_head <= r_new;
                cll_pkg::HD_LINK: r_head <= link_n;
                default:          r_head <= r_head;
            endcase
            case (i_cmd.free_sel)
                cll_pkg::FR_LINK: r_free <= link_rd;
                cll_pkg::FR_CUR:  r_free <= r_cur;
                default:          r_free <= r_free;
            endcase
            if (i_cmd.lnk_wr) begin
                r_lv[wr_addr[AW-1:0]] <= 1'b1;
            end
            if (i_cmd.out_ld) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign out_free = !r_ovalid || !i_out_stall;
    assign pos9     = {r_pos[cll_pkg::POS_W-1], r_pos};
    assign cnt9     = $signed((cll_pkg::POS_W + 1)'(r_cnt) + (cll_pkg::POS_W + 1)'(1));

    always_comb begin
        o_stat.free_null = r_free >= SLOTS_S;
        o_stat.head_null = r_head >= SLOTS_S;
        o_stat.cur_null  = r_cur >= SLOTS_S;
        o_stat.prev_null = r_prev >= SLOTS_S;
        o_stat.link_null = link_rd >= SLOTS_S;
        o_stat.hit       = r_kq == r_key;
        o_stat.cnt_full  = r_cnt >= CNT_FULL;
        o_stat.cnt_last  = r_cnt >= CNT_LAST;
        o_stat.pos_front = r_pos == '0;
        o_stat.pos_go    = (r_pos == cll_pkg::POS_END) || (cnt9 < pos9);
        o_stat.is_delete = r_type == cll_pkg::REQ_DELETE;
        o_stat.out_free  = out_free;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

// ===== src/cll_ctrl.sv =====
// cll_ctrl: request sequencer for the cursor linked list engine
// issues command beats to cll_dpath from its status; uses cll_pkg
module cll_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [cll_pkg::REQ_W-1:0]   i_req_type,
    input  cll_pkg::t_stat              i_stat,
    output logic                        o_in_stall,
    output cll_pkg::t_cmd               o_cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_INS_ALLOC = 4'd1;
    localparam logic [3:0] S_INS_LINK  = 4'd2;
    localparam logic [3:0] S_INS_WALK  = 4'd3;
    localparam logic [3:0] S_INS_TAIL  = 4'd4;
    localparam logic [3:0] S_FIND_GO   = 4'd5;
    localparam logic [3:0] S_FIND_STEP = 4'd6;
    localparam logic [3:0] S_DEL_FREE  = 4'd7;
    localparam logic [3:0] S_WALK_GO   = 4'd8;
    localparam logic [3:0] S_WALK_STEP = 4'd9;
    localparam logic [3:0] S_EMIT      = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_req_type)
                        cll_pkg::REQ_INSERT: n_state = S_INS_ALLOC;
                        cll_pkg::REQ_WALK:   n_state = S_WALK_GO;
                        default:             n_state = S_FIND_GO;
                    endcase
                end
            end
            S_INS_ALLOC: begin
                if (i_stat.free_null) begin
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_sel = cll_pkg::RES_FULL;
                    n_state       = S_EMIT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = cll_pkg::RD_FREE;
                    o_cmd.key_wr = 1'b1;
                    o_cmd.new_ld = 1'b1;
                    n_state      = S_INS_LINK;
                end
            end
            S_INS_LINK: begin
                o_cmd.free_sel = cll_pkg::FR_LINK;
                if (i_stat.head_null || i_stat.pos_front) begin
                    o_cmd.lnk_wr   = 1'b1;
                    o_cmd.lnk_wa   = cll_pkg::WA_NEW;
                    o_cmd.lnk_wd   = cll_pkg::WD_HEAD;
                    o_cmd.head_sel = cll_pkg::HD_NEW;
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_sel  = cll_pkg::RES_INS_OK;
                    n_state        = S_EMIT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = cll_pkg::RD_CUR;
                    n_state      = S_INS_WALK;
                end
            end
            S_INS_WALK: begin
                if (!i_stat.link_null && !i_stat.cnt_full && i_stat.pos_go) begin
                    o_cmd.step   = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = cll_pkg::RD_LINK;
                end else begin
                    o_cmd.lnk_wr = 1'b1;
                    o_cmd.lnk_wa = cll_pkg::WA_NEW;
                    o_cmd.lnk_wd = cll_pkg::WD_LINK;
                    n_state      = S_INS_TAIL;
                end
            end
            S_INS_TAIL: begin
                o_cmd.lnk_wr  = 1'b1;
                o_cmd.lnk_wa  = cll_pkg::WA_CUR;
                o_cmd.lnk_wd  = cll_pkg::WD_NEW;
                o_cmd.res_ld  = 1'b1;
                o_cmd.res_sel = cll_pkg::RES_INS_OK;
                n_state       = S_EMIT;
            end
            S_FIND_GO: begin
                if (i_stat.cur_null) begin
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_sel = cll_pkg::RES_NOT_FOUND;
                    n_state       = S_EMIT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = cll_pkg::RD_CUR;
                    n_state      = S_FIND_STEP;
                end
            end
            S_FIND_STEP: begin
                if (i_stat.hit) begin
                    if (i_stat.is_delete) begin
                        if (i_stat.prev_null) begin
                            o_cmd.head_sel = cll_pkg::HD_LINK;
                        end else begin
                            o_cmd.lnk_wr = 1'b1;
                            o_cmd.lnk_wa = cll_pkg::WA_PREV;
                            o_cmd.lnk_wd = cll_pkg::WD_LINK;
                        end
                        n_state = S_DEL_FREE;
                    end else begin
                        o_cmd.res_ld  = 1'b1;
                        o_cmd.res_sel = cll_pkg::RES_CUR_OK;
                        n_state       = S_EMIT;
                    end
                end else if (i_stat.link_null || i_stat.cnt_last) begin
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_sel = cll_pkg::RES_NOT_FOUND;
                    n_state       = S_EMIT;
                end else begin
                    o_cmd.step   = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = cll_pkg::RD_LINK;
                end
            end
            S_DEL_FREE: begin
                o_cmd.lnk_wr   = 1'b1;
                o_cmd.lnk_wa   = cll_pkg::WA_CUR;
                o_cmd.lnk_wd   = cll_pkg::WD_FREE;
                o_cmd.free_sel = cll_pkg::FR_CUR;
                o_cmd.res_ld   = 1'b1;
                o_cmd.res_sel  = cll_pkg::RES_CUR_OK;
                n_state        = S_EMIT;
            end
            S_WALK_GO: begin
                if (i_stat.cur_null) begin
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_sel = cll_pkg::RES_EMPTY;
                    n_state       = S_EMIT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = cll_pkg::RD_CUR;
                    n_state      = S_WALK_STEP;
                end
            end
            S_WALK_STEP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_walk = 1'b1;
                    if (i_stat.link_null || i_stat.cnt_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.step   = 1'b1;
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = cll_pkg::RD_LINK;
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/cursor_linked_list_engine.sv =====
// cursor_linked_list_engine: array-backed singly linked list of keys with a free slot list
// insert takes a free slot and walks to its position, delete and search walk from the head node by node
// walk: beats follow the list from the head, one beat per cycle while the output is taken
// one item at a time: the next request is taken once the last beat of the current one is registered
// synchronous active-low reset: list empty, all slots free in order, no clearing pass needed
module cursor_linked_list_engine #(
    parameter int SLOTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cll_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cll_pkg::t_out_item o_out_data
);

    cll_pkg::t_cmd  cmd;
    cll_pkg::t_stat stat;

    cll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_data.req_type),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    cll_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== src/cll_checker.sv =====
// cll_checker: port-level checks for cursor_linked_list_engine, bound to the top level
// uses cll_pkg
module cll_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input cll_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input cll_pkg::t_out_item o_out_data
);

    // held beat stays valid
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // held beat keeps its payload
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // an accepted request makes the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted back to back");

    // error results are single closing beats with zero slot and key
    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != cll_pkg::ST_OK) |->
            o_out_data.last && (o_out_data.slot == '0) && (o_out_data.found_key == '0))
        else $error("malformed error beat");

    // no new request while a walk is still streaming
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> o_in_stall)
        else $error("input open during walk");

endmodule

bind cursor_linked_list_engine cll_checker u_cll_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== verif/cursor_linked_list_engine_tb.sv =====
// testbench for cursor_linked_list_engine: random and directed list requests on the request
// channel, every result beat checked against an in-bench list predictor with its own slot store
// depends on cll_pkg for the beat structs and the request and status codes
`timescale 1ns / 1ps

module testbench;

    localparam int SLOTS = 32;

    typedef struct {
        cll_pkg::t_in_item req;
        int                gap;
        bit                settle;
    } t_stim;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    cll_pkg::t_in_item  req_beat = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    cll_pkg::t_out_item rsp_beat;

    // predicted list state
    logic [cll_pkg::SLOT_W-1:0] lnk [SLOTS];
    logic [cll_pkg::KEY_W-1:0]  keys [SLOTS];
    logic [cll_pkg::SLOT_W-1:0] head_slot;
    logic [cll_pkg::SLOT_W-1:0] free_slot;

    t_stim              stim_q[$];
    cll_pkg::t_out_item due_results[$];
    t_stim              cur_stim;
    bit                 have_cur = 1'b0;
    int                 gap_left = 0;
    int                 rsp_wait = 0;
    int                 hold_left = 0;
    bit                 hold_done = 1'b0;
    int                 beats_seen = 0;
    int                 fails = 0;
    bit                 req_fire = 1'b0;
    bit                 rsp_fire = 1'b0;
    logic               nxt_valid;
    cll_pkg::t_in_item  nxt_req;
    cll_pkg::t_out_item want;
    logic [15:0]        key_pool [12];

    cursor_linked_list_engine #(.SLOTS(SLOTS)) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_data   (req_beat),
        .o_out_valid (rsp_valid),
        .i_out_stall (rsp_stall),
        .o_out_data  (rsp_beat)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [cll_pkg::SLOT_W-1:0] or_null(logic [cll_pkg::SLOT_W-1:0] s);
        return (s < SLOTS) ? s : cll_pkg::NULL_SLOT;
    endfunction

    function automatic string fmt_beat(cll_pkg::t_out_item b);
        return $sformatf("status %0d slot %0d key %h last %b",
                         b.status, b.slot, b.found_key, b.last);
    endfunction

    function automatic void queue_result(logic [cll_pkg::STAT_W-1:0] st,
                                         logic [cll_pkg::SLOT_W-1:0] sl,
                                         logic [cll_pkg::KEY_W-1:0] k, logic lst);
        cll_pkg::t_out_item r;
        r.status    = st;
        r.slot      = sl;
        r.found_key = k;
        r.last      = lst;
        due_results.push_back(r);
    endfunction

    function automatic void apply_request(cll_pkg::t_in_item it);
        int                         pos;
        int                         i;
        logic [cll_pkg::SLOT_W-1:0] n;
        logic [cll_pkg::SLOT_W-1:0] cur;
        logic [cll_pkg::SLOT_W-1:0] prev;
        logic [cll_pkg::SLOT_W-1:0] nxt;
        pos = $signed(it.position);
        case (it.req_type)
            cll_pkg::REQ_INSERT: begin
                n = free_slot;
                if (n >= SLOTS) begin
                    queue_result(cll_pkg::ST_FULL, '0, '0, 1'b1);
                end else begin
                    free_slot = lnk[n];
                    keys[n] = it.key;
                    if (head_slot >= SLOTS || pos == 0) begin
                        lnk[n] = or_null(head_slot);
                        head_slot = n;
                    end else begin
                        cur = head_slot;
                        i = 0;
                        while (lnk[cur] < SLOTS && i < SLOTS &&
                               (pos == -1 || i < pos - 1)) begin
                            cur = lnk[cur];
                            i++;
                        end
                        lnk[n] = or_null(lnk[cur]);
                        lnk[cur] = n;
                    end
                    queue_result(cll_pkg::ST_OK, n, it.key, 1'b1);
                end
            end
            cll_pkg::REQ_DELETE: begin
                cur = head_slot;
                prev = cll_pkg::NULL_SLOT;
                i = 0;
                while (cur < SLOTS && i < SLOTS && keys[cur] != it.key) begin
                    prev = cur;
                    cur = lnk[cur];
                    i++;
                end
                if (cur >= SLOTS || i >= SLOTS) begin
                    queue_result(cll_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
                end else begin
                    if (prev >= SLOTS)
                        head_slot = or_null(lnk[cur]);
                    else
                        lnk[prev] = or_null(lnk[cur]);
                    lnk[cur] = or_null(free_slot);
                    free_slot = cur;
                    queue_result(cll_pkg::ST_OK, cur, it.key, 1'b1);
                end
            end
            cll_pkg::REQ_SEARCH: begin
                cur = head_slot;
                i = 0;
                while (cur < SLOTS && i < SLOTS && keys[cur] != it.key) begin
                    cur = lnk[cur];
                    i++;
                end
                if (cur >= SLOTS || i >= SLOTS)
                    queue_result(cll_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
                else
                    queue_result(cll_pkg::ST_OK, cur, it.key, 1'b1);
            end
            default: begin
                if (head_slot >= SLOTS) begin
                    queue_result(cll_pkg::ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    cur = head_slot;
                    i = 0;
                    while (cur < SLOTS && i < SLOTS) begin
                        nxt = lnk[cur];
                        queue_result(cll_pkg::ST_OK, cur, keys[cur],
                                     nxt >= SLOTS || i + 1 >= SLOTS);
                        cur = nxt;
                        i++;
                    end
                end
            end
        endcase
    endfunction

    function automatic t_stim make_req(logic [cll_pkg::REQ_W-1:0] op,
                                       logic [cll_pkg::KEY_W-1:0] k, int pos,
                                       bit burst, bit settle);
        t_stim s;
        s.req.req_type = op;
        s.req.key      = k;
        s.req.position = pos[cll_pkg::POS_W-1:0];
        s.gap          = burst ? 0 : $urandom_range(0, 7);
        s.settle       = settle;
        return s;
    endfunction

    function automatic logic [cll_pkg::REQ_W-1:0] pick_op(int w_ins, int w_del, int w_find);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_ins)
            return cll_pkg::REQ_INSERT;
        if (r < w_ins + w_del)
            return cll_pkg::REQ_DELETE;
        if (r < w_ins + w_del + w_find)
            return cll_pkg::REQ_SEARCH;
        return cll_pkg::REQ_WALK;
    endfunction

    function automatic logic [cll_pkg::KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, 11)];
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic int pick_pos();
        case ($urandom_range(0, 9))
            0, 1, 2: return -1;
            3:       return 0;
            4, 5, 6: return int'($urandom_range(1, 6));
            7:       return int'($urandom_range(7, 64));
            8:       return 1;
            default: return -int'($urandom_range(2, 128));
        endcase
    endfunction

    // request driver
    always @(negedge clk) begin
        nxt_valid = req_valid;
        nxt_req   = req_beat;
        if (!rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (req_fire)
                nxt_valid = 1'b0;
            if (!nxt_valid && !have_cur && stim_q.size() != 0) begin
                cur_stim = stim_q.pop_front();
                have_cur = 1'b1;
                gap_left = cur_stim.gap;
            end
            if (!nxt_valid && have_cur && !(cur_stim.settle && due_results.size() != 0)) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    nxt_valid = 1'b1;
                    nxt_req   = cur_stim.req;
                    have_cur  = 1'b0;
                end
            end
        end
        req_valid <= nxt_valid;
        req_beat  <= nxt_req;
    end

    // result receiver
    always @(negedge clk) begin
        if (!rst_n) begin
            rsp_wait = 0;
            rsp_stall <= 1'b0;
        end else begin
            if (rsp_fire)
                rsp_wait = ((beats_seen / 32) % 4 == 3) ? 0 : $urandom_range(0, 7);
            if (hold_left != 0) begin
                rsp_stall <= 1'b1;
            end else if (rsp_wait > 0) begin
                rsp_wait--;
                rsp_stall <= 1'b1;
            end else begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // long hold-off on the result side so the engine backs up
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && beats_seen >= 40) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
    end

    // monitor and checker
    always @(posedge clk) begin
        req_fire = rst_n && req_valid && req_stall === 1'b0;
        rsp_fire = rst_n && rsp_valid === 1'b1 && !rsp_stall;
        if (!rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                lnk[i]  = (i + 1 < SLOTS) ? cll_pkg::SLOT_W'(i + 1) : cll_pkg::NULL_SLOT;
                keys[i] = '0;
            end
            head_slot = cll_pkg::NULL_SLOT;
            free_slot = '0;
        end else begin
            if (rsp_fire) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, got %s",
                             $time, fmt_beat(rsp_beat));
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    if (rsp_beat.status !== want.status || rsp_beat.slot !== want.slot ||
                        rsp_beat.found_key !== want.found_key ||
                        rsp_beat.last !== want.last) begin
                        $display("%0t: beat mismatch: expected %s, got %s",
                                 $time, fmt_beat(want), fmt_beat(rsp_beat));
                        fails++;
                    end
                end
                beats_seen <= beats_seen + 1;
            end
            if (req_fire)
                apply_request(req_beat);
        end
    end

    initial begin
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hffff;
        for (int i = 2; i < 12; i++)
            key_pool[i] = 16'($urandom_range(0, 65535));

        // directed: empty list cases, every position kind, duplicates, head and tail delete
        stim_q.push_back(make_req(cll_pkg::REQ_WALK,   16'h0000, 0, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_SEARCH, 16'h0000, 0, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_DELETE, 16'h0005, 0, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_INSERT, 16'hffff, 5, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_INSERT, 16'h0000, 0, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_INSERT, 16'd100, -1, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_INSERT, 16'd200, 1, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_INSERT, 16'd300, 64, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_INSERT, 16'd400, -128, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_INSERT, 16'd500, 2, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_INSERT, 16'h5aa5, 127, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_INSERT, 16'd600, -2, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_WALK,   16'hffff, -1, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_SEARCH, 16'hffff, 0, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_SEARCH, 16'd300, 0, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_SEARCH, 16'd7777, 0, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_INSERT, 16'd100, 0, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_DELETE, 16'd100, 0, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_SEARCH, 16'd100, 0, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_DELETE, 16'h0000, 0, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_DELETE, 16'h5aa5, 0, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_DELETE, 16'd4242, 0, 0, 0));
        stim_q.push_back(make_req(cll_pkg::REQ_WALK,   16'h0000, 0, 0, 0));

        // mixed traffic
        for (int i = 0; i < 60; i++)
            stim_q.push_back(make_req(pick_op(45, 25, 20), pick_key(), pick_pos(),
                                      i >= 20 && i < 35, 1'b0));
        // fill past full after the engine has drained, then mostly deletes
        for (int i = 0; i < 36; i++)
            stim_q.push_back(make_req(cll_pkg::REQ_INSERT, pick_key(), pick_pos(), 1'b0,
                                      i == 0));
        stim_q.push_back(make_req(cll_pkg::REQ_WALK, pick_key(), pick_pos(), 1'b0, 1'b0));
        for (int i = 0; i < 30; i++)
            stim_q.push_back(make_req(pick_op(10, 60, 25), pick_key(), pick_pos(), 1'b0,
                                      1'b0));
        stim_q.push_back(make_req(cll_pkg::REQ_WALK, pick_key(), pick_pos(), 1'b0, 1'b0));
        for (int i = 0; i < 20; i++)
            stim_q.push_back(make_req(pick_op(40, 30, 20), pick_key(), pick_pos(),
                                      i >= 5 && i < 15, 1'b0));

        @(posedge clk iff rst_n);
        do
            @(posedge clk);
        while (stim_q.size() != 0 || have_cur || req_valid || due_results.size() != 0);
        repeat (40) @(posedge clk);
        if (fails == 0)
            $display("[cursor_linked_list_engine] OK");
        else
            $display("[cursor_linked_list_engine] ERROR");
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("[cursor_linked_list_engine] ERROR");
        $finish;
    end

endmodule
